/* rtl/core/spt_pkg.sv */
// shared types, sizes and a name helper for the sorted part table
`default_nettype none
package spt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int NAME_CHARS  = 8;
  localparam int KEY_W       = 32;
  localparam int QTY_W       = 32;
  localparam int NAME_W      = 64;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_IDLE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [QTY_W-1:0] qty;
    logic [NAME_W-1:0]       name;
  } rec_t;

  typedef struct packed {
    logic valid;
    logic lt;
    logic eq;
  } cell_stat_t;

  // keep bytes up to the first zero byte, at most NAME_CHARS of them
  function automatic logic [NAME_W-1:0] cut_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    logic              alive;
    kept  = '0;
    alive = 1'b1;
    for (int i = 0; i < NAME_CHARS; i++) begin
      if (raw[8*i +: 8] == 8'h00) alive = 1'b0;
      if (alive) kept[8*i +: 8] = raw[8*i +: 8];
    end
    return kept;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/spt_cell.sv */
// one table slot: holds a record, compares it with a key and shifts with its neighbours
`default_nettype none
module spt_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cmp_en,
  input  wire logic signed [31:0] cmp_key,
  input  wire spt_pkg::cell_op_t  op,
  input  wire spt_pkg::rec_t      new_rec,
  input  wire spt_pkg::rec_t      left_rec,
  input  wire logic               left_lt,
  input  wire logic               left_valid,
  input  wire spt_pkg::rec_t      right_rec,
  input  wire logic               right_valid,
  output spt_pkg::rec_t           rec,
  output spt_pkg::cell_stat_t     stat
);
  import spt_pkg::*;

  rec_t rec_r, rec_nxt;
  logic valid_r, valid_nxt;
  logic lt_r, lt_nxt;
  logic eq_r, eq_nxt;

  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    case (op)
      OP_INSERT: begin
        // cells at or after the insert point move up by one
        if (!lt_r) begin
          rec_nxt   = left_lt ? new_rec : left_rec;
          valid_nxt = valid_r | left_valid;
        end
      end
      OP_DELETE: begin
        // cells at or after the hit move down by one
        if (!lt_r) begin
          rec_nxt   = right_rec;
          valid_nxt = right_valid;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (cmp_en) begin
      lt_nxt = valid_r && ($signed(rec_r.key) < cmp_key);
      eq_nxt = valid_r && (rec_r.key == cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      lt_r    <= lt_nxt;
      eq_r    <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec        = rec_r;
  assign stat.valid = valid_r;
  assign stat.lt    = lt_r;
  assign stat.eq    = eq_r;

endmodule
`default_nettype wire

/* rtl/core/sorted_part_table_top.sv */
// Sorted part table: a row of 16 cells keeps part records in ascending signed part number
// order. On the transfer every cell compares its key with the incoming part number and the
// command is held; once the output register is free, the row shifts up (insert) or down
// (delete) in one step and the result is loaded into the output register. in_tready is
// low while a command is held, so no new command is taken until the held one is applied.
// Insert of a new part number into a full table returns status 2 and stores nothing; a
// duplicate insert, or a delete or find of an absent part number, returns status 1; names
// keep the bytes up to the first zero byte.
`default_nettype none
module sorted_part_table_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // mode[1:0], part_number[33:2], quantity[65:34], part_name[129:66], zero fill
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[1:0], found_quantity[33:2], found_name[97:34], zero fill
  output logic [103:0]      out_tdata
);
  import spt_pkg::*;

  logic                    in_xfer;
  logic                    apply;
  logic                    busy_r, busy_nxt;
  mode_t                   cmd_mode_r;
  rec_t                    cmd_rec_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              out_status_r;
  logic [QTY_W-1:0]        out_qty_r;
  logic [NAME_W-1:0]       out_name_r;
  status_t                 status;
  logic [QTY_W-1:0]        res_qty;
  logic [NAME_W-1:0]       res_name;
  logic                    hit;
  logic                    full;
  logic [QTY_W-1:0]        hit_qty;
  logic [NAME_W-1:0]       hit_name;
  cell_op_t                cell_op;
  rec_t                    cell_rec  [TABLE_DEPTH];
  cell_stat_t              cell_stat [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  valid_vec;
  logic [TABLE_DEPTH-1:0]  eq_vec;

  assign in_tready = !busy_r;
  assign in_xfer   = in_tvalid && !busy_r;
  assign apply     = busy_r && (!out_valid_r || out_tready);

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      rec_t left_rec;
      logic left_lt;
      logic left_valid;
      rec_t right_rec;
      logic right_valid;
      if (g == 0) begin : g_first
        assign left_rec   = cmd_rec_r;
        assign left_lt    = 1'b1;
        assign left_valid = 1'b1;
      end else begin : g_mid
        assign left_rec   = cell_rec[g-1];
        assign left_lt    = cell_stat[g-1].lt;
        assign left_valid = cell_stat[g-1].valid;
      end
      if (g == TABLE_DEPTH - 1) begin : g_last
        assign right_rec   = '0;
        assign right_valid = 1'b0;
      end else begin : g_inner
        assign right_rec   = cell_rec[g+1];
        assign right_valid = cell_stat[g+1].valid;
      end
      spt_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmp_en      (in_xfer),
        .cmp_key     ($signed(in_tdata[33:2])),
        .op          (cell_op),
        .new_rec     (cmd_rec_r),
        .left_rec    (left_rec),
        .left_lt     (left_lt),
        .left_valid  (left_valid),
        .right_rec   (right_rec),
        .right_valid (right_valid),
        .rec         (cell_rec[g]),
        .stat        (cell_stat[g])
      );
      assign valid_vec[g] = cell_stat[g].valid;
      assign eq_vec[g]    = cell_stat[g].eq;
    end
  endgenerate

  // keys are unique, so at most one cell matches and an or-tree picks its record
  always_comb begin
    hit_qty  = '0;
    hit_name = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (eq_vec[i]) begin
        hit_qty  = hit_qty | cell_rec[i].qty;
        hit_name = hit_name | cell_rec[i].name;
      end
    end
  end

  assign hit  = |eq_vec;
  assign full = valid_vec[TABLE_DEPTH-1];

  always_comb begin
    cell_op  = OP_IDLE;
    status   = ST_MISS;
    res_qty  = '0;
    res_name = '0;
    case (cmd_mode_r)
      MODE_INSERT: begin
        if (hit) begin
          status = ST_MISS;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          status  = ST_DONE;
          cell_op = apply ? OP_INSERT : OP_IDLE;
        end
      end
      MODE_DELETE: begin
        if (hit) begin
          status  = ST_DONE;
          cell_op = apply ? OP_DELETE : OP_IDLE;
        end
      end
      MODE_FIND: begin
        if (hit) begin
          status   = ST_DONE;
          res_qty  = hit_qty;
          res_name = hit_name;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_xfer) busy_nxt = 1'b1;
    else if (apply) busy_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (apply) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_mode_r     <= mode_t'(in_tdata[1:0]);
      cmd_rec_r.key  <= $signed(in_tdata[33:2]);
      cmd_rec_r.qty  <= $signed(in_tdata[65:34]);
      cmd_rec_r.name <= cut_name(in_tdata[129:66]);
    end
    if (apply) begin
      out_status_r <= status;
      out_qty_r    <= res_qty;
      out_name_r   <= res_name;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_name_r, out_qty_r, out_status_r};

  // occupied cells always form an unbroken run from the bottom of the row
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + TABLE_DEPTH'(1))) == '0)
    else $error("occupied cells not contiguous");

  // never two cells holding the same part number
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(eq_vec))
    else $error("more than one cell matched");

  // a result only appears after a command has been held for compare
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(busy_r))
    else $error("result without a command");

  // a delete that shifts the row always frees the top cell
  assert property (@(posedge clk) disable iff (!rst_n)
    (cell_op == OP_DELETE) |=> !valid_vec[TABLE_DEPTH-1])
    else $error("top cell still occupied after delete");

endmodule
`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for the sorted part table: directed rows, then random traffic
`default_nettype none
module tb;
  import spt_pkg::*;

  typedef struct packed {
    status_t           st;
    logic [QTY_W-1:0]  qty;
    logic [NAME_W-1:0] name;
  } part_result_t;

  typedef struct packed {
    mode_t             mode;
    logic [KEY_W-1:0]  key;
    logic [QTY_W-1:0]  qty;
    logic [NAME_W-1:0] name;
    logic              known;
    part_result_t      res;
  } cmd_row_t;

  localparam logic [31:0] S32_MIN      = 32'h8000_0000;
  localparam logic [31:0] S32_MAX      = 32'h7fff_ffff;
  localparam int          N_ROWS       = 28;
  localparam int          RAND_ITEMS   = 1500;
  localparam int          PRESS_ITEMS  = 60;
  localparam int          LONG_HOLD    = 300;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          N_POOL       = 20;

  localparam part_result_t NO_RES = '{ST_DONE, 32'd0, 64'd0};

  // known answers where they are obvious, the predictor elsewhere
  localparam cmd_row_t CMD_ROWS [N_ROWS] = '{
    '{MODE_FIND,   32'd0,        32'd0,   64'd0,                 1'b1, '{ST_MISS, 32'd0, 64'd0}},
    '{MODE_NONE,   32'h1234_5678, 32'hffff_ffff, 64'h4142_4344_4546_4748,
                                                                 1'b1, '{ST_MISS, 32'd0, 64'd0}},
    '{MODE_INSERT, S32_MIN,      S32_MAX, 64'hffff_ffff_ffff_ffff, 1'b1, NO_RES},
    '{MODE_INSERT, S32_MAX,      S32_MIN, 64'd0,                 1'b1, NO_RES},
    '{MODE_INSERT, 32'd0,        32'd42,  64'h4847_4600_4443_4241, 1'b1, NO_RES},
    '{MODE_FIND,   S32_MIN,      32'd0,   64'd0,                 1'b1,
      '{ST_DONE, S32_MAX, 64'hffff_ffff_ffff_ffff}},
    '{MODE_FIND,   S32_MAX,      32'd0,   64'd0,                 1'b1, '{ST_DONE, S32_MIN, 64'd0}},
    // name stops at the first zero byte
    '{MODE_FIND,   32'd0,        32'd0,   64'd0,                 1'b1,
      '{ST_DONE, 32'd42, 64'h0000_0000_4443_4241}},
    '{MODE_INSERT, S32_MIN,      32'd5,   64'h55,                1'b1, '{ST_MISS, 32'd0, 64'd0}},
    '{MODE_DELETE, 32'd5,        32'd0,   64'd0,                 1'b1, '{ST_MISS, 32'd0, 64'd0}},
    '{MODE_INSERT, -32'sd1000,   32'd1,   64'h6162_6364_6566_6700, 1'b0, NO_RES},
    '{MODE_INSERT, -32'sd3,      32'd2,   64'h41,                1'b0, NO_RES},
    '{MODE_INSERT, -32'sd2,      32'd3,   64'h0102_0304_0506_0708, 1'b0, NO_RES},
    '{MODE_INSERT, -32'sd1,      32'd4,   64'h8000_0000_0000_0001, 1'b0, NO_RES},
    '{MODE_INSERT, 32'd1,        32'd5,   64'h3131,              1'b0, NO_RES},
    '{MODE_INSERT, 32'd2,        32'd6,   64'h00ff_00ff_00ff_00ff, 1'b0, NO_RES},
    '{MODE_INSERT, 32'd3,        32'd7,   64'hff00_ff00_ff00_ff00, 1'b0, NO_RES},
    '{MODE_INSERT, 32'd100,      32'd8,   64'h5a5a_5a5a_5a5a_5a5a, 1'b0, NO_RES},
    '{MODE_INSERT, 32'd7,        32'd9,   64'ha5a5_a5a5_a5a5_a5a5, 1'b0, NO_RES},
    '{MODE_INSERT, 32'd8,        32'd10,  64'h7700_0000_0000_6677, 1'b0, NO_RES},
    '{MODE_INSERT, 32'd9,        32'd11,  64'h2a,                1'b0, NO_RES},
    '{MODE_INSERT, 32'd10,       32'd12,  64'h4040_4040,         1'b0, NO_RES},
    '{MODE_INSERT, 32'd11,       32'd13,  64'h6f6f_6f6f_6f6f,    1'b0, NO_RES},
    '{MODE_FIND,   -32'sd3,      32'd0,   64'd0,                 1'b0, NO_RES},
    '{MODE_INSERT, 32'd999,      32'd1,   64'h99,                1'b1, '{ST_FULL, 32'd0, 64'd0}},
    // duplicate wins over full
    '{MODE_INSERT, 32'd0,        32'd1,   64'h11,                1'b1, '{ST_MISS, 32'd0, 64'd0}},
    '{MODE_DELETE, 32'd0,        32'd0,   64'd0,                 1'b1, NO_RES},
    '{MODE_FIND,   32'd0,        32'd0,   64'd0,                 1'b1, '{ST_MISS, 32'd0, 64'd0}}
  };

  localparam logic [31:0] KEY_POOL [N_POOL] = '{
    S32_MIN, S32_MIN + 32'd1, -32'sd65536, -32'sd1000, -32'sd3, -32'sd2, -32'sd1, 32'd0,
    32'd1, 32'd2, 32'd3, 32'd7, 32'd100, 32'd255, 32'd65535, 32'h1234_5678,
    32'h4000_0000, 32'hc000_0000, S32_MAX - 32'd1, S32_MAX
  };

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [135:0]  in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [103:0]  out_tdata;

  logic          cur_known;
  part_result_t  cur_known_res;
  int            idle_pct;
  int            stall_pct;
  logic          long_hold_go;
  int            hold_count;

  logic signed [KEY_W-1:0] stored_keys  [TABLE_DEPTH];
  logic [QTY_W-1:0]        stored_qtys  [TABLE_DEPTH];
  logic [NAME_W-1:0]       stored_names [TABLE_DEPTH];
  int                      stored_count;

  part_result_t awaited_results [$];
  int           err_count;
  int           cmds_taken;
  int           results_checked;
  int           status_tally [4];

  sorted_part_table_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= 30) $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] kept;
    int                n;
    kept = '0;
    n    = 0;
    while (n < NAME_CHARS && raw[8*n +: 8] != 8'h00) begin
      kept[8*n +: 8] = raw[8*n +: 8];
      n++;
    end
    return kept;
  endfunction

  // applies one command to the shadow table and returns its result
  function automatic part_result_t apply_part_cmd(input mode_t m, input logic signed [31:0] k,
                                                  input logic [31:0] q, input logic [63:0] n);
    part_result_t r;
    int           pos;
    logic         hit;
    r   = '{ST_MISS, 32'd0, 64'd0};
    pos = 0;
    while (pos < stored_count && stored_keys[pos] < k) pos++;
    hit = (pos < stored_count) && (stored_keys[pos] == k);
    case (m)
      MODE_INSERT: begin
        if (hit) begin
          r.st = ST_MISS;
        end else if (stored_count >= TABLE_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          for (int i = stored_count; i > pos; i--) begin
            stored_keys[i]  = stored_keys[i-1];
            stored_qtys[i]  = stored_qtys[i-1];
            stored_names[i] = stored_names[i-1];
          end
          stored_keys[pos]  = k;
          stored_qtys[pos]  = q;
          stored_names[pos] = trim_name(n);
          stored_count++;
          r.st = ST_DONE;
        end
      end
      MODE_DELETE: begin
        if (hit) begin
          for (int i = pos; i + 1 < stored_count; i++) begin
            stored_keys[i]  = stored_keys[i+1];
            stored_qtys[i]  = stored_qtys[i+1];
            stored_names[i] = stored_names[i+1];
          end
          stored_count--;
          r.st = ST_DONE;
        end
      end
      MODE_FIND: begin
        if (hit) begin
          r.st   = ST_DONE;
          r.qty  = stored_qtys[pos];
          r.name = stored_names[pos];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // result side first, then the command transfer of the same edge
  always @(posedge clk) begin
    part_result_t seen;
    part_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        seen.st   = status_t'(out_tdata[1:0]);
        seen.qty  = out_tdata[33:2];
        seen.name = out_tdata[97:34];
        if (awaited_results.size() == 0) begin
          flag_mismatch("result transfer with no command outstanding");
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (seen.st !== want.st)
            flag_mismatch($sformatf("status %0d, wanted %0d", seen.st, want.st));
          if (seen.qty !== want.qty)
            flag_mismatch($sformatf("found_quantity %0d, wanted %0d",
                                    $signed(seen.qty), $signed(want.qty)));
          if (seen.name !== want.name)
            flag_mismatch($sformatf("found_name %h, wanted %h", seen.name, want.name));
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_part_cmd(mode_t'(in_tdata[1:0]), in_tdata[33:2], in_tdata[65:34],
                              in_tdata[129:66]);
        if (cur_known) want = cur_known_res;
        awaited_results.push_back(want);
        status_tally[want.st]++;
        cmds_taken++;
      end
    end
  end

  // result side: random stalls, plus one long hold to back the block up
  always @(posedge clk) begin
    if (long_hold_go && hold_count < LONG_HOLD) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic offer_cmd(input mode_t m, input logic [31:0] k, input logic [31:0] q,
                           input logic [63:0] n, input logic known, input part_result_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid     <= 1'b1;
    in_tdata      <= {6'd0, n, q, k, m};
    cur_known     <= known;
    cur_known_res <= res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // filling leans towards inserts so the table often runs full, otherwise towards deletes
  task automatic offer_random(input bit filling);
    int          pick;
    int          byte_sel;
    mode_t       m;
    logic [31:0] k;
    logic [31:0] q;
    logic [63:0] n;
    pick = $urandom_range(99);
    if (pick < (filling ? 50 : 30))      m = MODE_INSERT;
    else if (pick < (filling ? 70 : 65)) m = MODE_DELETE;
    else if (pick < 95)                  m = MODE_FIND;
    else                                 m = MODE_NONE;
    if ($urandom_range(7) == 0) k = $urandom;
    else                        k = KEY_POOL[$urandom_range(N_POOL-1)];
    case ($urandom_range(9))
      0:       q = S32_MIN;
      1:       q = S32_MAX;
      default: q = $urandom;
    endcase
    n        = {$urandom, $urandom};
    byte_sel = $urandom_range(7);
    case ($urandom_range(5))
      0:       n = '0;
      1:       n = '1;
      2:       n[8*byte_sel +: 8] = 8'h00;
      default: ;
    endcase
    offer_cmd(m, k, q, n, 1'b0, NO_RES);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    cur_known     = 1'b0;
    cur_known_res = NO_RES;
    idle_pct      = 0;
    stall_pct     = 0;
    long_hold_go  = 1'b0;
    hold_count    = 0;
    stored_count  = 0;
    err_count     = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      stored_keys[i]  = '0;
      stored_qtys[i]  = '0;
      stored_names[i] = '0;
    end
    for (int i = 0; i < 4; i++) status_tally[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct  = 31;
    stall_pct = 31;
    for (int r = 0; r < N_ROWS; r++)
      offer_cmd(CMD_ROWS[r].mode, CMD_ROWS[r].key, CMD_ROWS[r].qty, CMD_ROWS[r].name,
                CMD_ROWS[r].known, CMD_ROWS[r].res);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 69; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int i = 0; i < RAND_ITEMS / 4; i++) offer_random((ph % 2) == 0);
    end

    // back-pressure: sender keeps offering while the result side holds off
    idle_pct     = 0;
    stall_pct    = 0;
    long_hold_go = 1'b1;
    for (int i = 0; i < PRESS_ITEMS; i++) offer_random(1'b1);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands and %0d checked results, incl. a %0d-cycle output hold",
             cmds_taken, results_checked, LONG_HOLD);
    $display("statuses seen: %0d done or found, %0d duplicate or absent, %0d table full",
             status_tally[ST_DONE], status_tally[ST_MISS], status_tally[ST_FULL]);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sorted_part_table_top.f */
rtl/core/spt_pkg.sv
rtl/core/spt_cell.sv
rtl/core/sorted_part_table_top.sv
dv/tb.sv
